>>> sv/edtt_pkg.sv
// ----------------------------------------------------------------------------
// edtt_pkg: shared types and codes for the earliest deadline timer table
// Operation and status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package edtt_pkg;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN1 = 6'b000010,
    S_ACT   = 6'b000100,
    S_SCAN2 = 6'b001000,
    S_DONE  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

endpackage

>>> sv/earliest_deadline_timer_table_core.sv
// ----------------------------------------------------------------------------
// earliest_deadline_timer_table_core: timer table with earliest-deadline fire
// Holds up to SLOTS timers; add, remove and tick words each give one result.
// ----------------------------------------------------------------------------
// Usage: each word on the in_ channel carries an opcode (add, remove, tick)
// and its operands. The block answers every word with exactly one result word
// on the out_ channel: a status, an id, the fire report and the earliest
// pending deadline with its period.
// One word passes through the first slot scan (S_SCAN1), the action state
// (S_ACT), the second scan for the earliest timer (S_SCAN2) and S_DONE,
// which registers the result and raises out_tvalid. With out_tready high the
// result leaves from S_OUT and the block returns to S_IDLE before it takes
// the next word. The scans step one slot per cycle through a single shared
// compare unit. in_tready is high only while the block is idle.
// Reset clears all slot valid bits, the id and order counters and the scan
// counter; slot contents are left as they are. A result waits in the output
// register while out_tready is low, and the next input word is taken only
// after that result has gone.
// ----------------------------------------------------------------------------
module earliest_deadline_timer_table_core
  import edtt_pkg::*;
#(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 48
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // opcode[1:0], deadline[49:2], period[97:50], event_tag[113:98],
  // timer_id[145:114], now_ms[193:146], handler_stop[194], zero fill to 200
  input  logic [199:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], result_id[33:2], fired[34], fired_tag[50:35],
  // next_deadline[98:51], next_period[146:99], queue_empty[147], zero fill
  output logic [151:0] out_tdata
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

  logic [SLOTS-1:0]     valid_r;
  logic [TIME_BITS-1:0] dl_mem [SLOTS];
  logic [TIME_BITS-1:0] per_mem [SLOTS];
  logic [31:0]          id_mem [SLOTS];
  logic [15:0]          tag_mem [SLOTS];
  logic [31:0]          ord_mem [SLOTS];
  logic [31:0]          id_cnt_r, ord_cnt_r;

  state_t state_r;
  logic [CW-1:0] cnt_r;
  logic [1:0]    op_r;
  logic [TIME_BITS-1:0] a_dl_r, a_per_r, now_r;
  logic [15:0]   a_tag_r;
  logic [31:0]   a_id_r;
  logic          stop_r;

  // Scan results
  logic          free_f_r, id_f_r, best_f_r;
  logic [IW-1:0] free_i_r, id_i_r, best_i_r;
  logic [TIME_BITS-1:0] best_dl_r, best_per_r;
  logic [31:0]   best_age_r;

  // Result fields
  logic [1:0]  status_r;
  logic [31:0] rid_r;
  logic        fired_r;
  logic [15:0] ftag_r;

  logic [IW-1:0] si;
  logic [31:0]   age;
  logic          better;
  assign si  = cnt_r[IW-1:0];
  assign age = ord_cnt_r - ord_mem[si];
  assign better = valid_r[si] && (!best_f_r || dl_mem[si] < best_dl_r ||
                  (dl_mem[si] == best_dl_r && age > best_age_r));

  logic [TIME_BITS-1:0] sum_t;
  assign sum_t = now_r + best_per_r;
  logic [31:0] id_inc;
  assign id_inc = (id_cnt_r + 32'd1 == 32'd0) ? 32'd1 : id_cnt_r + 32'd1;

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      valid_r    <= '0;
      id_cnt_r   <= '0;
      ord_cnt_r  <= '0;
      out_tvalid <= 1'b0;
      cnt_r      <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r    <= in_tdata[1:0];
            a_dl_r  <= TIME_BITS'(in_tdata[49:2]);
            a_per_r <= TIME_BITS'(in_tdata[97:50]);
            a_tag_r <= in_tdata[113:98];
            a_id_r  <= in_tdata[145:114];
            now_r   <= TIME_BITS'(in_tdata[193:146]);
            stop_r  <= in_tdata[194];
            free_f_r <= 1'b0;
            id_f_r   <= 1'b0;
            best_f_r <= 1'b0;
            status_r <= ST_OK;
            rid_r    <= '0;
            fired_r  <= 1'b0;
            ftag_r   <= '0;
            cnt_r    <= '0;
            state_r  <= S_SCAN1;
          end
        end
        S_SCAN1: begin
          if (!valid_r[si] && !free_f_r) begin
            free_f_r <= 1'b1;
            free_i_r <= si;
          end
          if (valid_r[si] && id_mem[si] == a_id_r && !id_f_r) begin
            id_f_r <= 1'b1;
            id_i_r <= si;
          end
          if (better) begin
            best_f_r   <= 1'b1;
            best_i_r   <= si;
            best_dl_r  <= dl_mem[si];
            best_per_r <= per_mem[si];
            best_age_r <= age;
          end
          if (cnt_r == CW'(SLOTS - 1)) state_r <= S_ACT;
          else cnt_r <= cnt_r + 1'b1;
        end
        S_ACT: begin
          unique case (op_r)
            OP_ADD: begin
              if (!free_f_r) begin
                status_r <= ST_FULL;
              end else begin
                valid_r[free_i_r] <= 1'b1;
                dl_mem[free_i_r]  <= a_dl_r;
                per_mem[free_i_r] <= a_per_r;
                tag_mem[free_i_r] <= a_tag_r;
                id_mem[free_i_r]  <= id_inc;
                ord_mem[free_i_r] <= ord_cnt_r;
                ord_cnt_r <= ord_cnt_r + 32'd1;
                id_cnt_r  <= id_inc;
                rid_r     <= id_inc;
              end
            end
            OP_REMOVE: begin
              if (!id_f_r) status_r <= ST_NOTFOUND;
              else valid_r[id_i_r] <= 1'b0;
            end
            OP_TICK: begin
              if (best_f_r && now_r >= best_dl_r) begin
                fired_r <= 1'b1;
                rid_r   <= id_mem[best_i_r];
                ftag_r  <= tag_mem[best_i_r];
                if (best_per_r != '0 && !stop_r) begin
                  // Saturate on carry out of the time width.
                  dl_mem[best_i_r]  <= (sum_t < now_r) ? TMAX : sum_t;
                  ord_mem[best_i_r] <= ord_cnt_r;
                  ord_cnt_r <= ord_cnt_r + 32'd1;
                end else begin
                  valid_r[best_i_r] <= 1'b0;
                end
              end
            end
            default: ;
          endcase
          best_f_r <= 1'b0;
          cnt_r    <= '0;
          state_r  <= S_SCAN2;
        end
        S_SCAN2: begin
          if (better) begin
            best_f_r   <= 1'b1;
            best_i_r   <= si;
            best_dl_r  <= dl_mem[si];
            best_per_r <= per_mem[si];
            best_age_r <= age;
          end
          if (cnt_r == CW'(SLOTS - 1)) state_r <= S_DONE;
          else cnt_r <= cnt_r + 1'b1;
        end
        S_DONE: begin
          out_tdata <= {4'd0, !best_f_r,
                        best_f_r ? 48'(best_per_r) : 48'd0,
                        best_f_r ? 48'(best_dl_r) : 48'd0,
                        ftag_r, fired_r, rid_r, status_r};
          out_tvalid <= 1'b1;
          state_r    <= S_OUT;
        end
        S_OUT: begin
          if (out_tready) begin
            out_tvalid <= 1'b0;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[34] && out_tdata[1:0] != ST_OK))
    else $error("fire with error status");
`endif

endmodule
